### design/onewire_bus_master_top_defines.svh
// Assertion macros for the block's top module.
// Each expects clk and arst_n in scope.
`ifndef ONEWIRE_BUS_MASTER_TOP_DEFINES_SVH
`define ONEWIRE_BUS_MASTER_TOP_DEFINES_SVH

// Same-cycle implication.
`define OWB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define OWB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/owb_pkg.sv
`timescale 1ns / 1ps
package owb_pkg;

	localparam int TICK_W         = 10;
	localparam int CFG_IDX_W      = 3;
	localparam int KIND_W         = 3;
	localparam int BYTE_W         = 8;
	localparam int BITS_PER_BYTE  = 8;
	localparam int BITS_LEFT_W    = 4;
	localparam int BIT_IDX_W      = 3;
	localparam int RECOVERY_TICKS = 410;

	localparam logic [TICK_W-1:0] RECOVERY_LAST = TICK_W'(RECOVERY_TICKS - 1);

	// item kinds
	localparam logic [KIND_W-1:0] KIND_TICK       = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RESET      = 3'd1;
	localparam logic [KIND_W-1:0] KIND_WRITE_BYTE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_READ_BYTE  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_WRITE_BIT  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_READ_BIT   = 3'd5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LOW     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_RELEASE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_RELEASE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_TAIL     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd7;

	localparam logic [TICK_W-1:0] SHORT_LOW_RST     = 10'd6;
	localparam logic [TICK_W-1:0] ONE_RELEASE_RST   = 10'd64;
	localparam logic [TICK_W-1:0] ZERO_LOW_RST      = 10'd60;
	localparam logic [TICK_W-1:0] ZERO_RELEASE_RST  = 10'd10;
	localparam logic [TICK_W-1:0] READ_SAMPLE_RST   = 10'd9;
	localparam logic [TICK_W-1:0] READ_TAIL_RST     = 10'd55;
	localparam logic [TICK_W-1:0] RESET_LOW_RST     = 10'd480;
	localparam logic [TICK_W-1:0] PRESENCE_WAIT_RST = 10'd70;

	typedef struct packed {
		logic [TICK_W-1:0] short_low;
		logic [TICK_W-1:0] one_release;
		logic [TICK_W-1:0] zero_low;
		logic [TICK_W-1:0] zero_release;
		logic [TICK_W-1:0] read_sample;
		logic [TICK_W-1:0] read_tail;
		logic [TICK_W-1:0] reset_low;
		logic [TICK_W-1:0] presence_wait;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] data_value;
		logic              line_level;
	} item_t;

	typedef struct packed {
		logic              drive_low;
		logic              busy_res;
		logic              done_res;
		logic [BYTE_W-1:0] read_value;
		logic              presence;
		logic              rejected;
	} res_t;

endpackage

### design/owb_cfg.sv
`timescale 1ns / 1ps
module owb_cfg
	import owb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_low     <= SHORT_LOW_RST;
			cfg_q.one_release   <= ONE_RELEASE_RST;
			cfg_q.zero_low      <= ZERO_LOW_RST;
			cfg_q.zero_release  <= ZERO_RELEASE_RST;
			cfg_q.read_sample   <= READ_SAMPLE_RST;
			cfg_q.read_tail     <= READ_TAIL_RST;
			cfg_q.reset_low     <= RESET_LOW_RST;
			cfg_q.presence_wait <= PRESENCE_WAIT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_SHORT_LOW:     cfg_q.short_low     <= cfg_data;
				CFG_ONE_RELEASE:   cfg_q.one_release   <= cfg_data;
				CFG_ZERO_LOW:      cfg_q.zero_low      <= cfg_data;
				CFG_ZERO_RELEASE:  cfg_q.zero_release  <= cfg_data;
				CFG_READ_SAMPLE:   cfg_q.read_sample   <= cfg_data;
				CFG_READ_TAIL:     cfg_q.read_tail     <= cfg_data;
				CFG_RESET_LOW:     cfg_q.reset_low     <= cfg_data;
				CFG_PRESENCE_WAIT: cfg_q.presence_wait <= cfg_data;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/owb_core.sv
`timescale 1ns / 1ps
module owb_core
	import owb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  res
);

	// PH_FIN: a write whose slots are all zero length, done on the next tick
	typedef enum logic [3:0] {
		PH_IDLE, PH_LOW, PH_WAIT, PH_SAMPLE, PH_TAIL,
		PH_RLOW, PH_RWAIT, PH_RSAMPLE, PH_RTAIL, PH_FIN
	} phase_t;

	typedef struct packed {
		phase_t                 phase;
		logic [TICK_W-1:0]      count;
		logic [BIT_IDX_W-1:0]   bit_idx;
		logic [BITS_LEFT_W-1:0] bits_left;
		logic [BYTE_W-1:0]      shift_byte;
		logic                   fin;
		logic                   fin_rst;
	} st_t;

	phase_t                 phase_q;
	logic [TICK_W-1:0]      count_q;
	logic [BIT_IDX_W-1:0]   bit_idx_q;
	logic [BITS_LEFT_W-1:0] bits_left_q;
	logic [BYTE_W-1:0]      shift_q;
	logic                   pres_q;
	logic                   is_read_q;

	st_t  nx;
	logic nx_pres;
	logic nx_is_read;

	// Skip every remaining write slot of zero length; stop at the first one
	// that takes bus time, or finish.
	function automatic st_t f_bound(input logic [BITS_LEFT_W-1:0] n,
			input logic [BYTE_W-1:0] s, input logic [BIT_IDX_W-1:0] bi, input cfg_t c);
		st_t               r;
		logic              found;
		logic [BIT_IDX_W-1:0] k;
		logic              nz;
		logic [TICK_W-1:0] low_t;
		logic [TICK_W-1:0] tail_t;
		found = 1'b0;
		k     = '0;
		for (int i = BITS_PER_BYTE - 1; i >= 0; i--) begin
			nz = s[i] ? ((c.short_low | c.one_release) != '0)
			          : ((c.zero_low | c.zero_release) != '0);
			if ((BITS_LEFT_W'(i) < n) && nz) begin
				found = 1'b1;
				k     = BIT_IDX_W'(i);
			end
		end
		low_t     = s[k] ? c.short_low : c.zero_low;
		tail_t    = s[k] ? c.one_release : c.zero_release;
		r.fin_rst = 1'b0;
		if (found) begin
			r.fin        = 1'b0;
			r.bit_idx    = bi + k;
			r.shift_byte = s >> k;
			r.bits_left  = n - {1'b0, k};
			r.phase      = (low_t != '0) ? PH_LOW : PH_TAIL;
			r.count      = (low_t != '0) ? low_t : tail_t;
		end else begin
			r.fin        = 1'b1;
			r.bit_idx    = bi + n[BIT_IDX_W-1:0];
			r.shift_byte = s >> n;
			r.bits_left  = '0;
			r.phase      = PH_IDLE;
			r.count      = '0;
		end
		return r;
	endfunction

	// Start of a read slot, past any zero-length periods.
	function automatic st_t f_rslot(input st_t b, input cfg_t c);
		st_t r;
		r = b;
		if (c.short_low != '0) begin
			r.phase = PH_LOW;
			r.count = c.short_low;
		end else if (c.read_sample != '0) begin
			r.phase = PH_WAIT;
			r.count = c.read_sample;
		end else begin
			r.phase = PH_SAMPLE;
			r.count = TICK_W'(1);
		end
		return r;
	endfunction

	always_comb begin
		st_t                    cur;
		st_t                    rta;
		st_t                    fin_rst_st;
		logic [BYTE_W-1:0]      sh;
		logic                   pr;
		logic [TICK_W-1:0]      cnt;
		logic [TICK_W-1:0]      tail_t;
		logic [BITS_LEFT_W-1:0] bl_dec;

		cur.phase      = phase_q;
		cur.count      = count_q;
		cur.bit_idx    = bit_idx_q;
		cur.bits_left  = bits_left_q;
		cur.shift_byte = shift_q;
		cur.fin        = 1'b0;
		cur.fin_rst    = 1'b0;

		nx         = cur;
		nx_pres    = pres_q;
		nx_is_read = is_read_q;
		res        = '0;

		sh = shift_q;
		if (phase_q == PH_SAMPLE)
			sh[bit_idx_q] = shift_q[bit_idx_q] | item.line_level;
		pr = (phase_q == PH_RSAMPLE) ? ~item.line_level : pres_q;
		cnt    = count_q - TICK_W'(1);
		bl_dec = (bits_left_q != '0) ? bits_left_q - BITS_LEFT_W'(1) : '0;
		tail_t = sh[0] ? cfg.one_release : cfg.zero_release;

		// end of a read slot
		rta            = cur;
		rta.shift_byte = sh;
		rta.bit_idx    = bit_idx_q + BIT_IDX_W'(1);
		rta.bits_left  = bl_dec;
		if (bl_dec == '0) begin
			rta.phase = PH_IDLE;
			rta.count = '0;
			rta.fin   = 1'b1;
		end else begin
			rta = f_rslot(rta, cfg);
		end

		fin_rst_st         = cur;
		fin_rst_st.phase   = PH_IDLE;
		fin_rst_st.count   = '0;
		fin_rst_st.fin     = 1'b1;
		fin_rst_st.fin_rst = 1'b1;

		case (item.kind) inside
			KIND_TICK: begin
				if (phase_q == PH_FIN) begin
					nx.phase     = PH_IDLE;
					res.done_res = 1'b1;
				end else if (phase_q != PH_IDLE) begin
					res.drive_low = (phase_q == PH_LOW) || (phase_q == PH_RLOW);
					nx_pres       = pr;
					nx.shift_byte = sh;
					nx.count      = cnt;
					if (cnt == '0) begin
						unique case (phase_q)
							PH_LOW: begin
								if (is_read_q) begin
									nx.phase = (cfg.read_sample != '0) ? PH_WAIT : PH_SAMPLE;
									nx.count = (cfg.read_sample != '0) ? cfg.read_sample
									                                   : TICK_W'(1);
								end else if (tail_t != '0) begin
									nx.phase = PH_TAIL;
									nx.count = tail_t;
								end else begin
									nx = f_bound(bl_dec, sh >> 1, bit_idx_q + BIT_IDX_W'(1), cfg);
								end
							end
							PH_WAIT: begin
								nx.phase = PH_SAMPLE;
								nx.count = TICK_W'(1);
							end
							PH_SAMPLE: begin
								if (cfg.read_tail > TICK_W'(1)) begin
									nx.phase = PH_TAIL;
									nx.count = cfg.read_tail - TICK_W'(1);
								end else begin
									nx = rta;
								end
							end
							PH_TAIL: begin
								if (is_read_q)
									nx = rta;
								else
									nx = f_bound(bl_dec, sh >> 1, bit_idx_q + BIT_IDX_W'(1), cfg);
							end
							PH_RLOW: begin
								nx.phase = (cfg.presence_wait != '0) ? PH_RWAIT : PH_RSAMPLE;
								nx.count = (cfg.presence_wait != '0) ? cfg.presence_wait
								                                     : TICK_W'(1);
							end
							PH_RWAIT: begin
								nx.phase = PH_RSAMPLE;
								nx.count = TICK_W'(1);
							end
							PH_RSAMPLE: begin
								if (RECOVERY_LAST != '0) begin
									nx.phase = PH_RTAIL;
									nx.count = RECOVERY_LAST;
								end else begin
									nx = fin_rst_st;
								end
							end
							PH_RTAIL: nx = fin_rst_st;
							default:  nx = cur;
						endcase
					end
					if (nx.fin) begin
						res.done_res = 1'b1;
						if (nx.fin_rst)
							res.presence = pr;
						else if (is_read_q)
							res.read_value = nx.shift_byte;
					end
				end
			end
			KIND_RESET, KIND_WRITE_BYTE, KIND_READ_BYTE, KIND_WRITE_BIT, KIND_READ_BIT: begin
				if (phase_q != PH_IDLE) begin
					res.rejected = 1'b1;
				end else begin
					nx.bit_idx = '0;
					case (item.kind) inside
						KIND_RESET: begin
							nx_is_read    = 1'b0;
							nx_pres       = 1'b0;
							nx.bits_left  = '0;
							nx.shift_byte = '0;
							if (cfg.reset_low != '0) begin
								nx.phase = PH_RLOW;
								nx.count = cfg.reset_low;
							end else if (cfg.presence_wait != '0) begin
								nx.phase = PH_RWAIT;
								nx.count = cfg.presence_wait;
							end else begin
								nx.phase = PH_RSAMPLE;
								nx.count = TICK_W'(1);
							end
						end
						KIND_READ_BYTE, KIND_READ_BIT: begin
							nx_is_read    = 1'b1;
							nx.bits_left  = (item.kind == KIND_READ_BYTE)
							              ? BITS_LEFT_W'(BITS_PER_BYTE) : BITS_LEFT_W'(1);
							nx.shift_byte = '0;
							nx = f_rslot(nx, cfg);
						end
						default: begin
							nx_is_read = 1'b0;
							if (item.kind == KIND_WRITE_BYTE)
								nx = f_bound(BITS_LEFT_W'(BITS_PER_BYTE), item.data_value,
									'0, cfg);
							else
								nx = f_bound(BITS_LEFT_W'(1),
									{{(BYTE_W-1){1'b0}}, item.data_value[0]}, '0, cfg);
							if (nx.fin)
								nx.phase = PH_FIN;
						end
					endcase
				end
			end
			default: nx = cur;
		endcase

		res.busy_res = (nx.phase != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			count_q     <= '0;
			bit_idx_q   <= '0;
			bits_left_q <= '0;
			shift_q     <= '0;
			pres_q      <= 1'b0;
			is_read_q   <= 1'b0;
		end else if (en) begin
			phase_q     <= nx.phase;
			count_q     <= nx.count;
			bit_idx_q   <= nx.bit_idx;
			bits_left_q <= nx.bits_left;
			shift_q     <= nx.shift_byte;
			pres_q      <= nx_pres;
			is_read_q   <= nx_is_read;
		end
	end

endmodule

### design/onewire_bus_master_top.sv
`timescale 1ns / 1ps
// 1-Wire bus master stepped by tick items, one per bus microsecond. Command
// items (reset/presence, byte or bit write, byte or bit read) start an
// operation; every tick item carries the sampled line level and returns the
// open-drain drive for that microsecond together with busy, done, the read
// value or presence, and a flag for a command rejected while busy. One item
// is taken every clock cycle when the result side keeps up: an item is held
// in the input register, the state update runs in a single pass and the
// result lands in the output register. Slot timings are in ticks and come
// from the eight configuration registers.
`include "onewire_bus_master_top_defines.svh"
module onewire_bus_master_top
	import owb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // [7:0] data_value, [8] line_level
	input  logic [KIND_W-1:0]    s_tuser,   // [2:0] kind
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
	                                        // [10:3] read_value, [11] presence, [12] rejected
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data
);

	item_t item_s1;
	logic  valid_s1;
	res_t  res_q;
	logic  out_valid_q;
	res_t  res;
	cfg_t  cfg;
	logic  advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.kind       <= s_tuser;
			item_s1.data_value <= s_tdata[7:0];
			item_s1.line_level <= s_tdata[8];
		end
		if (advance)
			res_q <= res;
	end

	owb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	owb_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, res_q.rejected, res_q.presence, res_q.read_value,
	                   res_q.done_res, res_q.busy_res, res_q.drive_low};

	`OWB_ASSERT_NOW(a_done_not_rejected, out_valid_q && res_q.done_res, !res_q.rejected, "done and rejected in one item")
	`OWB_ASSERT_NOW(a_done_idle, out_valid_q && res_q.done_res, !res_q.busy_res, "busy still set on done")
	`OWB_ASSERT_NOW(a_read_with_done, out_valid_q && (res_q.read_value != '0), res_q.done_res, "read value without done")
	`OWB_ASSERT_NOW(a_ready_when_empty, !out_valid_q, s_tready, "input stalled with empty output register")
	`OWB_ASSERT_NEXT(a_result_loaded, advance, out_valid_q, "processed item did not reach output")

endmodule
